FILE: hw/rtl/msau_pkg.sv
package msau_pkg;

  localparam int ALARM_SLOTS = 8;
  localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [2:0] {
    MODE_BROWSE = 3'd0,
    MODE_HOUR   = 3'd1,
    MODE_MINUTE = 3'd2,
    MODE_SECOND = 3'd3,
    MODE_ONOFF  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SCAN_END,
    ST_EDIT_RD,
    ST_EDIT_WR,
    ST_SHOW_RD,
    ST_SHOW
  } ctrl_state_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic       button_back;
    logic       button_mode;
    logic       button_change;
  } in_item_t;

  typedef struct packed {
    logic       ring;
    logic       leave_screen;
    logic [2:0] edit_mode;
    logic [2:0] selected_slot;
    logic [4:0] slot_hour;
    logic [5:0] slot_minute;
    logic [5:0] slot_second;
    logic       slot_enabled;
  } out_item_t;

  typedef struct packed {
    logic       on;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } slot_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic edit_wr;
    logic show_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_time;
    logic edit_req;
    logic scan_last;
  } dp_status_t;

endpackage

FILE: hw/rtl/msau_ctrl.sv
module msau_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  msau_pkg::dp_status_t status,
  output msau_pkg::dp_cmd_t    cmd,
  output logic                 busy
);
  import msau_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.is_time)       state_nxt = ST_SCAN;
        else if (status.edit_req) state_nxt = ST_EDIT_RD;
        else                      state_nxt = ST_SHOW_RD;
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_SHOW_RD;
      ST_EDIT_RD:  state_nxt = ST_EDIT_WR;
      ST_EDIT_WR:  state_nxt = ST_SHOW_RD;
      ST_SHOW_RD:  state_nxt = ST_SHOW;
      ST_SHOW:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN:    cmd.scan_rd  = 1'b1;
      ST_EDIT_WR: cmd.edit_wr  = 1'b1;
      ST_SHOW:    cmd.show_out = 1'b1;
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_DISPATCH))
    else $error("accepted transaction did not dispatch");

  a_show_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHOW) |=> (state_r == ST_IDLE && !busy))
    else $error("controller did not return to idle after result");

  a_edit_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EDIT_RD) |=> cmd.edit_wr)
    else $error("edit read not followed by write");
`endif

endmodule

FILE: hw/rtl/msau_datapath.sv
module msau_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msau_pkg::in_item_t   in_data,
  input  msau_pkg::dp_cmd_t    cmd,
  output msau_pkg::dp_status_t status,
  output logic                 out_valid,
  output msau_pkg::out_item_t  out_data
);
  import msau_pkg::*;

  slot_entry_t             mem [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0]  vld_r;

  in_item_t    item_r;
  mode_t       mode_r;
  slot_idx_t   slot_r;
  slot_idx_t   scan_idx_r;
  slot_idx_t   prev_idx_r;
  logic        cmp_vld_r;
  logic        ring_r;
  logic        leave_r;
  slot_entry_t rd_data_r;
  logic        rd_vld_r;
  out_item_t   out_r;
  logic        out_valid_r;

  slot_entry_t rd_entry;
  slot_idx_t   rd_addr;
  logic        hit;
  logic        wr_en;
  slot_idx_t   wr_addr;
  slot_entry_t wr_data;
  slot_entry_t edit_entry;
  mode_t       mode_a;
  mode_t       mode_b;
  logic        leave_a;
  slot_idx_t   slot_b;

  // unwritten entries read as the reset value
  assign rd_entry = rd_vld_r ? rd_data_r : '0;
  assign rd_addr  = cmd.scan_rd ? scan_idx_r : slot_r;

  assign hit = cmp_vld_r && rd_entry.on &&
               (rd_entry.hour == item_r.now_hour) &&
               (rd_entry.minute == item_r.now_minute) &&
               (rd_entry.second == item_r.now_second);

  // button sequence: back, then mode, then change
  always_comb begin
    mode_a  = mode_r;
    leave_a = 1'b0;
    if (in_data.button_back) begin
      if (mode_r inside {[MODE_HOUR:MODE_ONOFF]}) mode_a = MODE_BROWSE;
      else                                        leave_a = 1'b1;
    end
    mode_b = mode_a;
    if (in_data.button_mode) begin
      if (mode_a inside {[MODE_HOUR:MODE_SECOND]}) mode_b = mode_t'(mode_a + 3'd1);
      else                                         mode_b = MODE_HOUR;
    end
    slot_b = slot_r;
    if (in_data.button_change && !(mode_b inside {[MODE_HOUR:MODE_ONOFF]})) begin
      if (slot_r == SLOT_W'(ALARM_SLOTS - 1)) slot_b = '0;
      else                                    slot_b = slot_r + 1'b1;
    end
  end

  always_comb begin
    edit_entry = rd_entry;
    case (mode_r)
      MODE_HOUR:   edit_entry.hour   = (rd_entry.hour >= 5'd23) ? 5'd0 : rd_entry.hour + 5'd1;
      MODE_MINUTE: edit_entry.minute = (rd_entry.minute >= 6'd59) ? 6'd0
                                                                  : rd_entry.minute + 6'd1;
      MODE_SECOND: edit_entry.second = (rd_entry.second >= 6'd59) ? 6'd0
                                                                  : rd_entry.second + 6'd1;
      MODE_ONOFF:  edit_entry.on     = ~rd_entry.on;
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = edit_entry;
    if (hit) begin
      wr_en      = 1'b1;
      wr_addr    = prev_idx_r;
      wr_data    = rd_entry;
      wr_data.on = 1'b0;
    end else if (cmd.edit_wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BROWSE;
      slot_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ring_r      <= 1'b0;
      leave_r     <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      cmp_vld_r   <= cmd.scan_rd;
      out_valid_r <= cmd.show_out;
      if (cmd.load) begin
        ring_r     <= 1'b0;
        scan_idx_r <= '0;
        if (in_data.kind) begin
          mode_r  <= mode_b;
          slot_r  <= slot_b;
          leave_r <= leave_a;
        end else begin
          leave_r <= 1'b0;
        end
      end
      if (cmd.scan_rd) scan_idx_r <= scan_idx_r + 1'b1;
      if (hit) ring_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)    item_r     <= in_data;
    if (cmd.scan_rd) prev_idx_r <= scan_idx_r;
    if (cmd.show_out) begin
      out_r.ring          <= ring_r;
      out_r.leave_screen  <= leave_r;
      out_r.edit_mode     <= mode_r;
      out_r.selected_slot <= 3'(slot_r);
      out_r.slot_hour     <= rd_entry.hour;
      out_r.slot_minute   <= rd_entry.minute;
      out_r.slot_second   <= rd_entry.second;
      out_r.slot_enabled  <= rd_entry.on;
    end
  end

  assign status.is_time   = ~item_r.kind;
  assign status.edit_req  = item_r.button_change && (mode_r inside {[MODE_HOUR:MODE_ONOFF]});
  assign status.scan_last = (scan_idx_r == SLOT_W'(ALARM_SLOTS - 1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit && cmd.edit_wr))
    else $error("scan clear and edit write collide");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(slot_r) < ALARM_SLOTS))
    else $error("selected slot out of range");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.edit_mode <= 3'd4))
    else $error("edit mode out of range on result");

  a_no_ring_on_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.ring && out_r.leave_screen))
    else $error("ring and leave_screen both set");
`endif

endmodule

FILE: hw/rtl/multi_slot_alarm_unit.sv
// Channel  | Ports                     | Transaction
// ---------+---------------------------+----------------------------------------
// input    | start, busy, in_data      | taken at an edge with start=1, busy=0
// result   | out_valid, out_data       | one cycle wide strobe, always taken
//
// Time check: the slot table is scanned one slot per cycle through its single
// read port. Button event: when a slot field is edited, the slot table goes
// through a read-modify-write before the result.
// The result strobe comes in the first cycle with busy low; a new transaction
// may be accepted in that same cycle. Reset (rst_n low, synchronous) empties the
// table, selects slot 0 in browse mode. The receiver cannot stall.
module multi_slot_alarm_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  msau_pkg::in_item_t  in_data,
  output logic                out_valid,
  output msau_pkg::out_item_t out_data
);
  import msau_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  msau_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  msau_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
